FILE: hdl/half_scale_box_downsampler_defines.svh
// Assertion macros shared by the downsampler RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef HALF_SCALE_BOX_DOWNSAMPLER_DEFINES_SVH
`define HALF_SCALE_BOX_DOWNSAMPLER_DEFINES_SVH
`ifndef ASSERT_OFF
`define HSBD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HSBD_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define HSBD_ASSERT(label, clk, rst, prop, msg)
`define HSBD_NEVER(label, clk, rst, cond, msg)
`endif
`endif

FILE: hdl/hsbd_pkg.sv
// Shared types, constants and the channel averaging function of the downsampler.
// No dependencies.
`default_nettype none
package hsbd_pkg;

  localparam int PIXEL_W      = 32;
  localparam int SRC_WIDTH_W  = 12;
  localparam int SRC_HEIGHT_W = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int CMD_DEPTH    = 4;
  localparam int OUT_DEPTH    = 4;
  localparam int OUT_CNT_W    = $clog2(OUT_DEPTH + 1);

  localparam logic [PIXEL_W-1:0] HALF_MASK = 32'hfefe_fefe;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROUND_UP   = 2'd2;

  typedef enum logic [1:0] {
    CMD_STORE,
    CMD_ROW,
    CMD_SELF
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t              op;
    logic                 frame_end;
    logic [PIXEL_W-1:0]   pixel;
  } cmd_t;

  function automatic logic [PIXEL_W-1:0] half_sum(input logic [PIXEL_W-1:0] a,
                                                  input logic [PIXEL_W-1:0] b);
    half_sum = ((a & HALF_MASK) >> 1) + ((b & HALF_MASK) >> 1);
  endfunction

endpackage
`default_nettype wire

FILE: hdl/hsbd_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module hsbd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [WIDTH-1:0]  wdata,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

FILE: hdl/hsbd_fifo.sv
// Small show-ahead queue with occupancy count.
// Uses the assertion macros header.
`default_nettype none
`include "half_scale_box_downsampler_defines.svh"
module hsbd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  full,
  output logic                  empty,
  output logic      [CNT_W-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `HSBD_NEVER(a_no_overflow, clk, rst, push && full, "word pushed into full queue")
  `HSBD_ASSERT(a_count_up, clk, rst, (do_push && !do_pop) |=> (count == $past(count) + 1'b1), "queue count did not advance")
  `HSBD_ASSERT(a_count_down, clk, rst, (do_pop && !do_push) |=> (count == $past(count) - 1'b1), "queue count did not drop")

endmodule
`default_nettype wire

FILE: hdl/hsbd_front.sv
// Front end: configuration registers, pixel position tracking, horizontal
// pairing and classification into line store and output commands. Uses hsbd_pkg.
`default_nettype none
module hsbd_front #(
  parameter int MAX_WIDTH = 2048,
  parameter int ADDR_W    = 10
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [hsbd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [hsbd_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                in_accept,
  input  wire logic [hsbd_pkg::PIXEL_W-1:0]        pixel_in,
  output logic                                     cmd_push,
  output hsbd_pkg::cmd_t                           cmd,
  output logic      [ADDR_W-1:0]                   cmd_addr
);
  import hsbd_pkg::*;

  localparam int CW   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int XW   = ((WW > SRC_WIDTH_W) ? WW : SRC_WIDTH_W) + 1;
  localparam int HW   = SRC_HEIGHT_W + 1;

  logic [SRC_WIDTH_W-1:0]  src_width;
  logic [SRC_HEIGHT_W-1:0] src_height;
  logic                    round_up;
  logic [PIXEL_W-1:0]      held_pixel;
  logic [CW-1:0]           column_count;
  logic [SRC_HEIGHT_W-1:0] row_count;

  logic [XW-1:0]           w_raw;
  logic [XW-1:0]           w_eff;
  logic [XW-1:0]           c_x;
  logic [HW-1:0]           h_eff;
  logic [HW-1:0]           r_x;
  logic                    last_col;
  logic                    last_row;
  logic                    col_keep;
  logic                    row_keep;
  logic                    final_col;
  logic                    final_row;
  logic                    have_h;
  logic [PIXEL_W-1:0]      hval;
  logic                    go;
  cmd_op_t                 op;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= SRC_WIDTH_W'(2);
      src_height <= SRC_HEIGHT_W'(2);
      round_up   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  src_width  <= cfg_data[SRC_WIDTH_W-1:0];
        REG_SRC_HEIGHT: src_height <= cfg_data[SRC_HEIGHT_W-1:0];
        REG_ROUND_UP:   round_up   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_raw = XW'(src_width);
    if (w_raw == '0) begin
      w_eff = XW'(1);
    end else if (w_raw > XW'(MAX_WIDTH)) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    h_eff = (src_height == '0) ? HW'(1) : HW'(src_height);
    c_x   = XW'(column_count);
    r_x   = HW'(row_count);

    last_col  = (c_x >= w_eff - 1'b1);
    last_row  = (r_x >= h_eff - 1'b1);
    col_keep  = round_up || (w_eff == XW'(1));
    row_keep  = round_up || (h_eff == HW'(1));
    final_col = last_col || ((c_x + XW'(2) >= w_eff) && !col_keep);
    final_row = last_row || ((r_x + HW'(2) >= h_eff) && !row_keep);

    if (!column_count[0]) begin
      have_h = last_col && col_keep;
      hval   = pixel_in;
    end else begin
      have_h = 1'b1;
      hval   = half_sum(held_pixel, pixel_in);
    end

    go = 1'b0;
    op = CMD_STORE;
    if (have_h) begin
      if (!row_count[0]) begin
        if (last_row) begin
          go = row_keep;
          op = CMD_SELF;
        end else begin
          go = 1'b1;
          op = CMD_STORE;
        end
      end else begin
        go = 1'b1;
        op = CMD_ROW;
      end
    end
  end

  assign cmd_push      = in_accept && go;
  assign cmd.op        = op;
  assign cmd.frame_end = final_col && final_row;
  assign cmd.pixel     = hval;
  assign cmd_addr      = ADDR_W'(column_count >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_pixel   <= '0;
      column_count <= '0;
      row_count    <= '0;
    end else if (in_accept) begin
      if (!column_count[0] && !last_col) begin
        held_pixel <= pixel_in;
      end
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + 1'b1;
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/hsbd_back.sv
// Back end: executes commands against the line store and forms the
// vertically averaged output words. Uses hsbd_pkg, hsbd_ram and the macros header.
`default_nettype none
`include "half_scale_box_downsampler_defines.svh"
module hsbd_back #(
  parameter int ROW_DEPTH = 1024,
  parameter int ADDR_W    = 10
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cmd_empty,
  input  wire hsbd_pkg::cmd_t                   cmd,
  input  wire logic [ADDR_W-1:0]                cmd_addr,
  output logic                                  cmd_pop,
  input  wire logic [hsbd_pkg::OUT_CNT_W-1:0]   out_count,
  output logic                                  res_valid,
  output logic      [hsbd_pkg::PIXEL_W-1:0]     res_pixel,
  output logic                                  res_frame_end
);
  import hsbd_pkg::*;

  logic                 credit_ok;
  logic                 ram_we;
  logic [PIXEL_W-1:0]   ram_q;
  logic                 s1_valid;
  cmd_op_t              s1_op;
  logic [PIXEL_W-1:0]   s1_pixel;
  logic                 s1_frame_end;

  assign credit_ok = (({1'b0, out_count} + (OUT_CNT_W + 1)'(s1_valid))
                      < (OUT_CNT_W + 1)'(OUT_DEPTH));
  assign cmd_pop   = !cmd_empty && credit_ok;
  assign ram_we    = cmd_pop && (cmd.op == CMD_STORE);

  hsbd_ram #(
    .WIDTH  (PIXEL_W),
    .DEPTH  (ROW_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_row_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (cmd_addr),
    .wdata (cmd.pixel),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= cmd_pop && (cmd.op != CMD_STORE);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      s1_op        <= cmd.op;
      s1_pixel     <= cmd.pixel;
      s1_frame_end <= cmd.frame_end;
    end
  end

  always_comb begin
    case (s1_op)
      CMD_ROW: res_pixel = half_sum(ram_q, s1_pixel);
      default: res_pixel = s1_pixel & HALF_MASK;
    endcase
  end

  assign res_valid     = s1_valid;
  assign res_frame_end = s1_frame_end;

  `HSBD_ASSERT(a_issue_to_result, clk, rst,
               (cmd_pop && cmd.op != CMD_STORE) |=> s1_valid,
               "result stage missed an issued word")
  `HSBD_ASSERT(a_result_from_issue, clk, rst, s1_valid |-> $past(cmd_pop),
               "result word without issue")
  `HSBD_NEVER(a_credit, clk, rst, s1_valid && (out_count == OUT_CNT_W'(OUT_DEPTH)),
              "result word with no room in output queue")

endmodule
`default_nettype wire

FILE: hdl/half_scale_box_downsampler.sv
// Half-scale 2x2 box downsampler for four-channel 32-bit pixels.
// Uses hsbd_pkg, hsbd_front, hsbd_fifo, hsbd_back.
//
// Input channel: a queue write side. A source pixel word on pixel_in is taken
// at a rising edge with push high and full low, in raster order.
// Output channel: a queue read side. While empty is low, pixel_out and
// frame_end show the oldest result word; it is taken at an edge with pop high.
// frame_end marks the last output word of a frame.
// Configuration: cfg_we writes cfg_data to register cfg_index
// (0 src_width, 1 src_height, 2 round_up) at a rising edge; write while idle.
// Throughput: one source pixel per cycle while full is low; every pixel passes
// the front end in its accept cycle; the back end issues one command a cycle
// while the output queue has room. A result word, self-averaged too, passes the
// command queue, result stage and output queue after its completing pixel.
// A stalled receiver fills the 4-word output queue, then the 4-word command
// queue; full rises once that is full. Reset: rst, synchronous, clears both
// queues and the position counters and sets width 2, height 2, round_up 0.
// The line store needs no clearing pass.
`default_nettype none
module half_scale_box_downsampler #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic [hsbd_pkg::PIXEL_W-1:0]       pixel_in,
  output logic                                    empty,
  input  wire logic                               pop,
  output logic      [hsbd_pkg::PIXEL_W-1:0]       pixel_out,
  output logic                                    frame_end,
  input  wire logic                               cfg_we,
  input  wire logic [hsbd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [hsbd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import hsbd_pkg::*;

  localparam int ROW_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int ADDR_W    = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
  localparam int CMD_W     = $bits(cmd_t) + ADDR_W;
  localparam int OUT_W     = PIXEL_W + 1;

  logic                  in_accept;
  logic                  cmd_push;
  cmd_t                  cmd_in;
  logic [ADDR_W-1:0]     cmd_addr_in;
  logic [CMD_W-1:0]      cmd_rd;
  cmd_t                  cmd_out;
  logic [ADDR_W-1:0]     cmd_addr_out;
  logic                  cmd_empty;
  logic                  cmd_pop;
  logic [$clog2(CMD_DEPTH + 1)-1:0] cmd_count;
  logic                  out_full;
  logic [OUT_CNT_W-1:0]  out_count;
  logic                  res_valid;
  logic [PIXEL_W-1:0]    res_pixel;
  logic                  res_frame_end;
  logic [OUT_W-1:0]      out_rd;
  logic                  cmd_full_unused;

  assign in_accept = push && !full;

  hsbd_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .ADDR_W    (ADDR_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_accept (in_accept),
    .pixel_in  (pixel_in),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in),
    .cmd_addr  (cmd_addr_in)
  );

  hsbd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd_push),
    .wr_data ({cmd_addr_in, cmd_in}),
    .pop     (cmd_pop),
    .rd_data (cmd_rd),
    .full    (full),
    .empty   (cmd_empty),
    .count   (cmd_count)
  );

  assign cmd_out         = cmd_rd[$bits(cmd_t)-1:0];
  assign cmd_addr_out    = cmd_rd[CMD_W-1:$bits(cmd_t)];
  assign cmd_full_unused = (cmd_count == '0) && full;

  hsbd_back #(
    .ROW_DEPTH (ROW_DEPTH),
    .ADDR_W    (ADDR_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_empty     (cmd_empty),
    .cmd           (cmd_out),
    .cmd_addr      (cmd_addr_out),
    .cmd_pop       (cmd_pop),
    .out_count     (out_count),
    .res_valid     (res_valid),
    .res_pixel     (res_pixel),
    .res_frame_end (res_frame_end)
  );

  hsbd_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (res_valid),
    .wr_data ({res_frame_end, res_pixel}),
    .pop     (pop),
    .rd_data (out_rd),
    .full    (out_full),
    .empty   (empty),
    .count   (out_count)
  );

  assign pixel_out = out_rd[PIXEL_W-1:0];
  assign frame_end = out_rd[PIXEL_W] && !(out_full && cmd_full_unused && empty);

endmodule
`default_nettype wire
